[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers included by the task picker design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off while reset is held.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, switched off while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pitp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitp_pkg
// Constants and codes of the priority-inheritance task picker.
// ----------------------------------------------------------------------------
package pitp_pkg;

  localparam int NUM_TASKS = 16;
  localparam int TASK_W    = $clog2(NUM_TASKS);
  localparam int ENTRY_W   = TASK_W + 1;

  // An entry with the top bit set means blocked with no holder.
  localparam logic [ENTRY_W-1:0] ENTRY_NONE = ENTRY_W'(NUM_TASKS);
  localparam logic [TASK_W-1:0]  LAST_TASK  = TASK_W'(NUM_TASKS - 1);

  localparam logic [1:0] ACT_RUNNABLE = 2'd0;
  localparam logic [1:0] ACT_BLOCK    = 2'd1;
  localparam logic [1:0] ACT_PICK     = 2'd2;
  localparam logic [1:0] ACT_UNUSED   = 2'd3;

endpackage

[design/priority_inheritance_task_picker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_inheritance_task_picker
// Blocked-on table per task and a chain-following picker over it.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. Runnable and block commands rewrite one table entry in that same
// cycle, give no result and leave busy low, so they may follow each other
// every cycle. A pick command raises busy and walks the table held in a
// synchronous RAM: task 0 first, following each blocked-on chain one hop
// per clock, since every hop is one read of the single RAM port. When the walk
// ends, the result word appears on the out_ ports for exactly one cycle with
// out_valid high. The receiver cannot stall; busy is already low in that
// cycle, so a new command may be taken. Chains longer than NUM_TASKS reads
// are cut off and flagged in cycle_seen. Reset clears per-entry valid bits,
// so every entry reads as zero (task 0 runnable, all others blocked on
// task 0) with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_inheritance_task_picker
  import pitp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [TASK_W-1:0] in_task_index,
  input  logic [TASK_W-1:0] in_blocker_index,
  input  logic              in_blocker_is_none,
  output logic              out_valid,
  output logic [TASK_W-1:0] out_chosen_task,
  output logic              out_task_found,
  output logic              out_cycle_seen
);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t              state_r, state_nxt;
  logic [TASK_W-1:0]   idx_r, idx_nxt;
  logic [TASK_W-1:0]   cur_r, cur_nxt;
  logic [TASK_W-1:0]   reads_r, reads_nxt;
  logic                cycle_r, cycle_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]   out_chosen_r, out_chosen_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_cycle_r, out_cycle_nxt;

  logic [ENTRY_W-1:0]  mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] valid_r;
  logic [ENTRY_W-1:0]  rd_data_r;
  logic                rd_valid_r;
  logic [TASK_W-1:0]   rd_addr;

  logic                accept;
  logic                wr_en;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  entry;
  logic                hit;
  logic                no_holder;
  logic                capped;

  assign busy    = (state_r == ST_WALK);
  assign accept  = start && !busy;
  assign wr_en   = accept && ((in_action == ACT_RUNNABLE) || (in_action == ACT_BLOCK));

  always_comb begin
    unique case (in_action)
      ACT_RUNNABLE: wr_data = {1'b0, in_task_index};
      ACT_BLOCK:    wr_data = in_blocker_is_none ? ENTRY_NONE : {1'b0, in_blocker_index};
      default:      wr_data = ENTRY_NONE;
    endcase
  end

  // An entry never written since reset reads as zero.
  assign entry     = rd_valid_r ? rd_data_r : '0;
  assign hit       = (entry == {1'b0, cur_r});
  assign no_holder = entry[TASK_W];
  assign capped    = (reads_r == LAST_TASK);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cur_nxt        = cur_r;
    reads_nxt      = reads_r;
    cycle_nxt      = cycle_r;
    out_valid_nxt  = 1'b0;
    out_chosen_nxt = out_chosen_r;
    out_found_nxt  = out_found_r;
    out_cycle_nxt  = out_cycle_r;
    rd_addr        = cur_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_PICK)) begin
          state_nxt = ST_WALK;
          idx_nxt   = '0;
          cur_nxt   = '0;
          reads_nxt = '0;
          cycle_nxt = 1'b0;
          rd_addr   = '0;
        end
      end
      ST_WALK: begin
        priority if (hit) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = cur_r;
          out_found_nxt  = 1'b1;
          out_cycle_nxt  = cycle_r;
        end else if (no_holder || capped) begin
          // This chain is over; a chain cut off at the cap is a deadlock.
          cycle_nxt = cycle_r | !no_holder;
          if (idx_r == LAST_TASK) begin
            state_nxt      = ST_IDLE;
            out_valid_nxt  = 1'b1;
            out_chosen_nxt = '0;
            out_found_nxt  = 1'b0;
            out_cycle_nxt  = cycle_r | !no_holder;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            cur_nxt   = idx_r + 1'b1;
            reads_nxt = '0;
            rd_addr   = idx_r + 1'b1;
          end
        end else begin
          cur_nxt   = entry[TASK_W-1:0];
          reads_nxt = reads_r + 1'b1;
          rd_addr   = entry[TASK_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      cur_r        <= '0;
      reads_r      <= '0;
      cycle_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_chosen_r <= '0;
      out_found_r  <= 1'b0;
      out_cycle_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      cur_r        <= cur_nxt;
      reads_r      <= reads_nxt;
      cycle_r      <= cycle_nxt;
      out_valid_r  <= out_valid_nxt;
      out_chosen_r <= out_chosen_nxt;
      out_found_r  <= out_found_nxt;
      out_cycle_r  <= out_cycle_nxt;
    end
  end

  // Table RAM: one write port for updates, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_task_index] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[in_task_index] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_task = out_chosen_r;
  assign out_task_found  = out_found_r;
  assign out_cycle_seen  = out_cycle_r;

  `ASSERT_NEXT(a_pick_goes_busy, clk, rst_n, accept && (in_action == ACT_PICK), busy, "pick word not followed by a walk")
  `ASSERT_SAME(a_result_after_walk, clk, rst_n, out_valid_r, $past(state_r == ST_WALK), "result without a walk")
  `ASSERT_SAME(a_no_task_zero, clk, rst_n, out_valid_r && !out_found_r, out_chosen_r == '0, "chosen task not zero when nothing found")
  `ASSERT_SAME(a_no_write_in_walk, clk, rst_n, busy, !wr_en, "table written during a walk")

endmodule
